// ----- hdl/pbcpd_pkg.sv -----
// Package: field widths, phase codes, error codes and payload types of the plane decoder.
package pbcpd_pkg;

    localparam int PIXEL_COUNT_BITS_DEF = 24;

    localparam int POS_W     = 24;
    localparam int CNT_CFG_W = 24;
    localparam int SKIP_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int COMP_W    = 16;
    localparam int ID_W      = 6;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SKIP = 3'd1;
    localparam logic [2:0] PH_HEAD = 3'd2;
    localparam logic [2:0] PH_LIT  = 3'd3;
    localparam logic [2:0] PH_REP  = 3'd4;
    localparam logic [2:0] PH_RAW  = 3'd5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CLIP  = 2'd1;
    localparam logic [1:0] ERR_COMP  = 2'd2;
    localparam logic [1:0] ERR_CHAN  = 2'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic       REG_PIXEL_COUNT = 1'b0;
    localparam logic       REG_LINE_TABLE  = 1'b1;

    localparam logic [BYTE_W-1:0] HDR_NOP     = 8'd128;
    localparam logic [ID_W-1:0]   ID_ALPHA    = 6'h3F;
    localparam logic [ID_W-1:0]   ID_LAST_COL = 6'd3;

    typedef struct packed {
        logic [1:0]        error;
        logic              plane_done;
        logic [BYTE_W-1:0] run_length;
        logic [BYTE_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic [1:0]        slot;
    } run_t;

endpackage

// ----- hdl/packbits_channel_plane_decoder.sv -----
// Top level: PackBits channel-plane decoder, one byte beat per cycle.
//
// Channel   Signals                                   Payload
// s_axis    s_axis_tvalid/tready/tdata/tuser          tdata: channel_id, compression_word,
//                                                     data_byte; tuser: kind
// m_axis    m_axis_tvalid/tready/tdata/tlast/tuser    tdata: slot, position, value,
//                                                     run_length; tlast: plane_done;
//                                                     tuser: error
// cfg       cfg_valid/cfg_ready/cfg_index/cfg_data    index 0 pixel_count, 1 line_table_bytes
//
// Each beat is decoded in the cycle it is accepted; a run it yields appears on m_axis in the cycle after.
// One beat per cycle sustained while m_axis_tready is high; the result register is the only stage.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// Reset clears all decode state and sets pixel_count to 1; cfg_ready is always high.
module packbits_channel_plane_decoder
#(
    parameter int PIXEL_COUNT_BITS = pbcpd_pkg::PIXEL_COUNT_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] channel_id, [21:6] compression_word, [29:22] data_byte, [31:30] zero
    input  logic [pbcpd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] slot, [25:2] position, [33:26] value, [41:34] run_length, [47:42] zero
    output logic [pbcpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    // [1:0] error
    output logic [1:0]                        m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [pbcpd_pkg::CNT_CFG_W-1:0]   cfg_data
);
    import pbcpd_pkg::*;

    localparam int PW = PIXEL_COUNT_BITS;
    localparam int CW = (PW > POS_W) ? PW : POS_W;

    logic [CNT_CFG_W-1:0] pixel_count_reg;
    logic [SKIP_W-1:0]    line_table_reg;

    logic [2:0]           phase_reg, phase_next;
    logic [BYTE_W-1:0]    literal_left_reg, literal_left_next;
    logic [SKIP_W-1:0]    skip_left_reg, skip_left_next;
    logic [PW-1:0]        pixel_pos_reg, pixel_pos_next;
    logic [1:0]           cur_slot_reg, cur_slot_next;
    logic [BYTE_W-1:0]    repeat_len_reg, repeat_len_next;

    logic                 out_valid_reg, out_valid_next;
    run_t                 out_run_reg, out_run_next;

    logic                 in_kind;
    logic [ID_W-1:0]      in_id;
    logic [COMP_W-1:0]    in_comp;
    logic [BYTE_W-1:0]    in_byte;
    logic                 accept;

    logic [CW-1:0]        count_ext;
    logic [PW-1:0]        count;
    logic [PW-1:0]        left;
    logic [BYTE_W-1:0]    want;
    logic [BYTE_W-1:0]    maxlen;
    logic [BYTE_W-1:0]    len;
    logic                 run_done;
    logic                 run_clip;
    logic [CW-1:0]        pos_ext;
    logic                 id_ok;
    logic [1:0]           id_slot;

    assign in_id   = s_axis_tdata[ID_W-1:0];
    assign in_comp = s_axis_tdata[ID_W+COMP_W-1:ID_W];
    assign in_byte = s_axis_tdata[ID_W+COMP_W+BYTE_W-1:ID_W+COMP_W];
    assign in_kind = s_axis_tuser;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2 - POS_W - 2*BYTE_W){1'b0}},
                            out_run_reg.run_length, out_run_reg.value,
                            out_run_reg.position, out_run_reg.slot};
    assign m_axis_tlast  = out_run_reg.plane_done;
    assign m_axis_tuser  = out_run_reg.error;

    assign id_ok   = (in_id == ID_ALPHA) || (in_id <= ID_LAST_COL);
    assign id_slot = ((in_id == ID_ALPHA) || (in_id == ID_LAST_COL))
                     ? 2'd3 : (2'd2 - in_id[1:0]);

    assign count_ext = CW'(pixel_count_reg);
    assign count     = count_ext[PW-1:0];
    assign left      = (count > pixel_pos_reg) ? (count - pixel_pos_reg) : '0;
    assign pos_ext   = CW'(pixel_pos_reg);

    always_comb
    begin
        case (phase_reg)
            PH_LIT:
            begin
                want   = literal_left_reg;
                maxlen = 8'd1;
            end
            PH_REP:
            begin
                want   = repeat_len_reg;
                maxlen = repeat_len_reg;
            end
            default:
            begin
                want   = 8'd1;
                maxlen = 8'd1;
            end
        endcase
    end

    assign len      = (PW'(maxlen) <= left) ? maxlen : BYTE_W'(left);
    assign run_done = PW'(want) >= left;
    assign run_clip = PW'(want) > left;

    always_comb
    begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        skip_left_next    = skip_left_reg;
        pixel_pos_next    = pixel_pos_reg;
        cur_slot_next     = cur_slot_reg;
        repeat_len_next   = repeat_len_reg;
        out_valid_next    = m_axis_tready ? 1'b0 : out_valid_reg;
        out_run_next      = out_run_reg;

        if (accept)
        begin
            if (in_kind == KIND_START)
            begin
                if (in_comp > 16'd1)
                begin
                    phase_next     = PH_IDLE;
                    out_valid_next = 1'b1;
                    out_run_next   = '0;
                    out_run_next.error = ERR_COMP;
                end
                else if (!id_ok)
                begin
                    phase_next     = PH_IDLE;
                    out_valid_next = 1'b1;
                    out_run_next   = '0;
                    out_run_next.error = ERR_CHAN;
                end
                else
                begin
                    cur_slot_next     = id_slot;
                    pixel_pos_next    = '0;
                    literal_left_next = '0;
                    repeat_len_next   = '0;
                    if (in_comp[0])
                    begin
                        skip_left_next = line_table_reg;
                        phase_next     = (line_table_reg != '0) ? PH_SKIP : PH_HEAD;
                    end
                    else
                    begin
                        skip_left_next = '0;
                        phase_next     = PH_RAW;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SKIP:
                    begin
                        skip_left_next = skip_left_reg - 16'd1;
                        if (skip_left_reg == 16'd1)
                        begin
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_HEAD:
                    begin
                        if (in_byte < HDR_NOP)
                        begin
                            literal_left_next = in_byte + 8'd1;
                            phase_next        = PH_LIT;
                        end
                        else if (in_byte > HDR_NOP)
                        begin
                            repeat_len_next = (~in_byte) + 8'd2;
                            phase_next      = PH_REP;
                        end
                    end
                    PH_LIT, PH_REP, PH_RAW:
                    begin
                        if (phase_reg == PH_LIT)
                        begin
                            phase_next        = (literal_left_reg > 8'd1) ? PH_LIT : PH_HEAD;
                            literal_left_next = literal_left_reg - 8'd1;
                        end
                        else if (phase_reg == PH_REP)
                        begin
                            phase_next = PH_HEAD;
                        end
                        if (run_done)
                        begin
                            phase_next = PH_IDLE;
                        end
                        pixel_pos_next          = pixel_pos_reg + PW'(len);
                        out_valid_next          = 1'b1;
                        out_run_next.slot       = cur_slot_reg;
                        out_run_next.position   = pos_ext[POS_W-1:0];
                        out_run_next.value      = in_byte;
                        out_run_next.run_length = len;
                        out_run_next.plane_done = run_done;
                        out_run_next.error      = run_clip ? ERR_CLIP : ERR_NONE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg  <= CNT_CFG_W'(1);
            line_table_reg   <= '0;
            phase_reg        <= PH_IDLE;
            literal_left_reg <= '0;
            skip_left_reg    <= '0;
            pixel_pos_reg    <= '0;
            cur_slot_reg     <= '0;
            repeat_len_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PIXEL_COUNT)
                begin
                    pixel_count_reg <= cfg_data;
                end
                else if (cfg_index == REG_LINE_TABLE)
                begin
                    line_table_reg <= cfg_data[SKIP_W-1:0];
                end
            end
            phase_reg        <= phase_next;
            literal_left_reg <= literal_left_next;
            skip_left_reg    <= skip_left_next;
            pixel_pos_reg    <= pixel_pos_next;
            cur_slot_reg     <= cur_slot_next;
            repeat_len_reg   <= repeat_len_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_run_reg <= out_run_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_run_reg.run_length <= 8'd128))
        else $error("run longer than a PackBits run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_run_reg.error == ERR_CLIP) |-> out_run_reg.plane_done)
        else $error("clipped run does not close the plane");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_run_reg.error == ERR_COMP || out_run_reg.error == ERR_CHAN))
        |-> (out_run_reg.run_length == 8'd0 && !out_run_reg.plane_done))
        else $error("plane-start error carries a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT) |-> (literal_left_reg != 8'd0))
        else $error("literal phase with no bytes left");

endmodule
